[hw/rtl/fsps_pkg.sv]
// ----------------------------------------------------------------------------
// fsps_pkg
// shared types and constants for the framed spi slave shifter
// ----------------------------------------------------------------------------
`default_nettype none

package fsps_pkg;

  // default size of the transmit data buffer
  localparam int BUF_BYTES_DEF = 48;

  localparam int BYTE_W  = 8;
  localparam int SLOT_W  = 3;
  localparam int INDEX_W = 6;

  // check constant: configured start byte plus received end byte
  localparam logic [BYTE_W-1:0] CHECK_SUM = 8'hFF;

  typedef enum logic [1:0] {
    CMD_CLOCK = 2'd0,
    CMD_START = 2'd1,
    CMD_END   = 2'd2,
    CMD_LOAD  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_LOW   = 3'd2,
    PH_HIGH  = 3'd3,
    PH_DATA  = 3'd4,
    PH_END   = 3'd5,
    PH_DONE  = 3'd6
  } phase_t;

  localparam logic [SLOT_W-1:0] SLOT_START = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_LOW   = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_HIGH  = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_DATA  = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_END   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_TX_START = 2'd0;
  localparam logic [1:0] REG_TX_LOW   = 2'd1;
  localparam logic [1:0] REG_TX_HIGH  = 2'd2;

  typedef struct packed {
    cmd_t               cmd;
    logic               mosi_bit;
    logic [INDEX_W-1:0] tx_index;
    logic [BYTE_W-1:0]  tx_value;
  } item_t;

  typedef struct packed {
    logic               miso_bit;
    logic               byte_done;
    logic [BYTE_W-1:0]  rx_byte;
    logic [SLOT_W-1:0]  rx_slot;
    logic [INDEX_W-1:0] rx_index;
    logic               check_failed;
    logic [BYTE_W-1:0]  error_count;
    logic               frame_active;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] low_byte;
    logic [BYTE_W-1:0] high_byte;
  } txcfg_t;

endpackage

`default_nettype wire

[hw/rtl/framed_spi_slave_shifter_unit.sv]
// ----------------------------------------------------------------------------
// framed_spi_slave_shifter_unit
// framed spi slave (mode 0, msb first) driven by a stream of edge/frame commands
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser cmd, tdata mosi/tx_index/tx_value
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata result fields
// cfg       in   cfg_we (no wait)             cfg_index, cfg_data
//
// one item per cycle sustained while the output drains: an accepted item sits in the
// input register, then the sequencer updates and loads the result register, which holds
// the result until the output takes it
// the buffer ram is read one item ahead with a write bypass, so edges need no wait
// rst is synchronous; it clears sequencer, counters, config and buffer valid bits
// a stalled output holds the input register; input ready drops only then
//
`default_nettype none

module framed_spi_slave_shifter_unit #(
  parameter int BUF_BYTES = fsps_pkg::BUF_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // mosi_bit, tx_index[5:0], tx_value[7:0], pad
  input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // miso_bit, byte_done, rx_byte[7:0],
                                           // rx_slot[2:0], rx_index[5:0], check_failed,
                                           // error_count[7:0], frame_active, pad
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  import fsps_pkg::*;

  localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;

  item_t             in_item;
  item_t             stage;
  logic              stage_valid;
  logic              fire;
  txcfg_t            txcfg;
  result_t           res;
  result_t           out_res;
  logic              out_valid;
  logic              buf_we;
  logic [AW-1:0]     buf_waddr;
  logic [AW-1:0]     buf_raddr;
  logic [BYTE_W-1:0] buf_byte;

  // unpack the incoming item
  assign in_item.cmd      = cmd_t'(s_axis_tuser);
  assign in_item.mosi_bit = s_axis_tdata[0];
  assign in_item.tx_index = s_axis_tdata[6:1];
  assign in_item.tx_value = s_axis_tdata[14:7];

  // the staged item is processed when the result register is free or draining
  assign fire          = stage_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !stage_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_axis_tready) begin
      stage_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      stage <= in_item;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      txcfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TX_START: txcfg.start_byte <= cfg_data;
        REG_TX_LOW:   txcfg.low_byte   <= cfg_data;
        REG_TX_HIGH:  txcfg.high_byte  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fsps_frame #(
    .BUF_BYTES (BUF_BYTES)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (stage),
    .txcfg     (txcfg),
    .buf_byte  (buf_byte),
    .res       (res),
    .buf_we    (buf_we),
    .buf_waddr (buf_waddr),
    .buf_raddr (buf_raddr)
  );

  fsps_txbuf #(
    .DEPTH (BUF_BYTES)
  ) u_txbuf (
    .clk   (clk),
    .rst   (rst),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (stage.tx_value),
    .raddr (buf_raddr),
    .rdata (buf_byte)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_res.frame_active, out_res.error_count,
                          out_res.check_failed, out_res.rx_index, out_res.rx_slot,
                          out_res.rx_byte, out_res.byte_done, out_res.miso_bit};

  // a failed check only comes with a completed end byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.check_failed |-> out_res.byte_done && out_res.rx_slot == SLOT_END)
    else $error("check failure without a completed end byte");

  // with no frame open the line idles high and no byte completes
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.frame_active |-> out_res.miso_bit && !out_res.byte_done)
    else $error("bit activity outside a frame");

  // the error counter moves only on a failed check
  assert property (@(posedge clk) disable iff (rst)
    fire && !res.check_failed && $past(fire) && !$past(rst) |->
      res.error_count == $past(res.error_count))
    else $error("error count changed without a failed check");

  // only data bytes carry a position
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.rx_slot != SLOT_DATA |-> out_res.rx_index == '0)
    else $error("position reported outside a data byte");

endmodule

`default_nettype wire

[hw/rtl/fsps_ram.sv]
// ----------------------------------------------------------------------------
// fsps_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module fsps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/fsps_txbuf.sv]
// ----------------------------------------------------------------------------
// fsps_txbuf
// transmit data buffer: ram plus per-entry valid bits and write bypass
// ----------------------------------------------------------------------------
`default_nettype none

module fsps_txbuf #(
  parameter int DEPTH = fsps_pkg::BUF_BYTES_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [fsps_pkg::BYTE_W-1:0] wdata,
  input  wire logic [AW-1:0]             raddr,
  output logic      [fsps_pkg::BYTE_W-1:0] rdata
);

  import fsps_pkg::*;

  logic [DEPTH-1:0]  valid;
  logic              rd_valid;
  logic              byp_hit;
  logic [BYTE_W-1:0] byp_data;
  logic [BYTE_W-1:0] ram_q;

  fsps_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
      byp_hit  <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rd_valid <= valid[raddr];
      byp_hit  <= we && (waddr == raddr);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= wdata;
  end

  assign rdata = byp_hit ? byp_data : (rd_valid ? ram_q : '0);

endmodule

`default_nettype wire

[hw/rtl/fsps_frame.sv]
// ----------------------------------------------------------------------------
// fsps_frame
// frame sequencer: phase, bit counter, receive shifter and frame check
// ----------------------------------------------------------------------------
`default_nettype none

module fsps_frame #(
  parameter int BUF_BYTES = fsps_pkg::BUF_BYTES_DEF,
  localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        fire,
  input  wire fsps_pkg::item_t             item,
  input  wire fsps_pkg::txcfg_t            txcfg,
  input  wire logic [fsps_pkg::BYTE_W-1:0] buf_byte,
  output fsps_pkg::result_t                res,
  output logic                             buf_we,
  output logic      [AW-1:0]               buf_waddr,
  output logic      [AW-1:0]               buf_raddr
);

  import fsps_pkg::*;

  localparam logic [AW-1:0] LAST_INDEX = AW'(BUF_BYTES - 1);

  phase_t            phase, phase_next;
  logic [2:0]        bit_pos, bit_pos_next;
  logic [BYTE_W-1:0] rx_shift, rx_shift_next;
  logic [AW-1:0]     data_index, data_index_next;
  logic [BYTE_W-1:0] start_compl, start_compl_next;
  logic [BYTE_W-1:0] fail_count, fail_count_next;
  logic [BYTE_W-1:0] tx_byte;
  logic [BYTE_W-1:0] shifted;
  logic [BYTE_W-1:0] check_sum;
  logic              shifting;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_pos     <= '0;
      rx_shift    <= '0;
      data_index  <= '0;
      start_compl <= '0;
      fail_count  <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      bit_pos     <= bit_pos_next;
      rx_shift    <= rx_shift_next;
      data_index  <= data_index_next;
      start_compl <= start_compl_next;
      fail_count  <= fail_count_next;
    end
  end

  // transmit byte of the current slot
  always_comb begin
    unique case (phase)
      PH_START: tx_byte = txcfg.start_byte;
      PH_LOW:   tx_byte = txcfg.low_byte;
      PH_HIGH:  tx_byte = txcfg.high_byte;
      PH_DATA:  tx_byte = buf_byte;
      PH_END:   tx_byte = start_compl;
      default:  tx_byte = '1;
    endcase
  end

  assign shifted   = {rx_shift[BYTE_W-2:0], item.mosi_bit};
  assign check_sum = txcfg.start_byte + shifted;
  assign shifting  = (phase == PH_START) || (phase == PH_LOW) || (phase == PH_HIGH) ||
                     (phase == PH_DATA) || (phase == PH_END);

  always_comb begin
    phase_next       = phase;
    bit_pos_next     = bit_pos;
    rx_shift_next    = rx_shift;
    data_index_next  = data_index;
    start_compl_next = start_compl;
    fail_count_next  = fail_count;
    res              = '0;
    res.miso_bit     = 1'b1;

    unique case (item.cmd)
      CMD_START: begin
        phase_next      = PH_START;
        bit_pos_next    = '0;
        rx_shift_next   = '0;
        data_index_next = '0;
      end
      CMD_END: begin
        phase_next    = PH_IDLE;
        bit_pos_next  = '0;
        rx_shift_next = '0;
      end
      CMD_LOAD: begin
      end
      CMD_CLOCK: begin
        if (shifting) begin
          res.miso_bit = tx_byte[~bit_pos];
          if (bit_pos == 3'd7) begin
            res.byte_done = 1'b1;
            res.rx_byte   = shifted;
            bit_pos_next  = '0;
            rx_shift_next = '0;
            unique case (phase)
              PH_START: begin
                res.rx_slot      = SLOT_START;
                start_compl_next = ~shifted;
                phase_next       = PH_LOW;
              end
              PH_LOW: begin
                res.rx_slot = SLOT_LOW;
                phase_next  = PH_HIGH;
              end
              PH_HIGH: begin
                res.rx_slot = SLOT_HIGH;
                phase_next  = PH_DATA;
              end
              PH_DATA: begin
                res.rx_slot  = SLOT_DATA;
                res.rx_index = INDEX_W'(data_index);
                if (data_index != LAST_INDEX) begin
                  data_index_next = data_index + 1'b1;
                end else begin
                  phase_next = PH_END;
                end
              end
              default: begin
                // end byte: frame check
                res.rx_slot = SLOT_END;
                if (check_sum != CHECK_SUM) begin
                  res.check_failed = 1'b1;
                  fail_count_next  = fail_count + 1'b1;
                end
                phase_next = PH_DONE;
              end
            endcase
          end else begin
            bit_pos_next  = bit_pos + 1'b1;
            rx_shift_next = shifted;
          end
        end
      end
    endcase

    res.error_count  = fail_count_next;
    res.frame_active = (phase_next != PH_IDLE);
  end

  assign buf_we    = fire && (item.cmd == CMD_LOAD) && (32'(item.tx_index) < BUF_BYTES);
  assign buf_waddr = AW'(item.tx_index);
  // read ahead the entry that the index holds after this cycle
  assign buf_raddr = fire ? data_index_next : data_index;

endmodule

`default_nettype wire
